>>> hw/rtl/mur64_pkg.sv
// mur64_pkg: shared types and constants for the MurmurHash64A table index hasher.
// Used by mur64_ctrl, mur64_dp and murmur64_table_index_hash_top. No dependencies.
`timescale 1ns / 1ps

package mur64_pkg;

  // Mixing multiplier and shift of MurmurHash64A
  localparam logic [63:0] MUR_M     = 64'hc6a4_a793_5bd1_e995;
  localparam logic [31:0] MUR_M_LO  = MUR_M[31:0];
  localparam logic [31:0] MUR_M_HI  = MUR_M[63:32];
  localparam int unsigned MUR_R     = 47;
  localparam logic [5:0]  TB_RESET  = 6'd8;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SEED_DONE,
    S_WORD,
    S_K1,
    S_K2,
    S_UPD,
    S_FIN0,
    S_FIN1,
    S_FOLD_INIT,
    S_FOLD,
    S_MUL0,
    S_MUL1,
    S_MUL2
  } state_t;

  // Source for the work register
  typedef enum logic [2:0] {
    W_HOLD,
    W_LEN,
    W_WORD,
    W_TAIL,
    W_XS,
    W_HXK,
    W_FIN0
  } wsel_t;

  // Step of the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MS_NONE,
    MS_0,
    MS_1,
    MS_2
  } mstep_t;

  // Source for the running hash
  typedef enum logic [1:0] {
    RH_HOLD,
    RH_SEED,
    RH_W
  } rhsel_t;

  typedef struct packed {
    logic   latch_in;
    wsel_t  w_sel;
    mstep_t mul_step;
    rhsel_t rh_sel;
    logic   fold_init;
    logic   fold_step;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic zero;
    logic fold_done;
  } dp_status_t;

endpackage

>>> hw/rtl/mur64_dp.sv
// mur64_dp: datapath of the hasher: input latch, running hash, work register,
// shared 32x32 multiplier, fold unit, config and result registers. Uses mur64_pkg.
`timescale 1ns / 1ps

module mur64_dp import mur64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [3:0]  word_bytes,
  input  logic [63:0] key_word,
  input  logic [31:0] key_length,
  input  logic [31:0] seed,
  input  logic        odd_step,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic [62:0] table_index,
  output logic [63:0] full_hash
);

  logic        first_q;
  logic        last_q;
  logic [3:0]  bytes_q;
  logic [63:0] word_q;
  logic [31:0] len_q;
  logic [31:0] seed_q;
  logic        odd_q;
  logic [5:0]  table_bits;
  logic [63:0] running_hash;
  logic [63:0] w;
  logic [63:0] w_next;
  logic [63:0] p;
  logic [63:0] j;
  logic [63:0] s;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] tail_mask;
  logic [63:0] idx_mask;

  // Write the table width register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_bits <= TB_RESET;
    end else if (cfg_write) begin
      table_bits <= cfg_data;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      first_q <= first_word;
      last_q  <= last_word;
      bytes_q <= word_bytes;
      word_q  <= key_word;
      len_q   <= key_length;
      seed_q  <= seed;
      odd_q   <= odd_step;
    end
  end

  assign tail_mask = (64'd1 << {bytes_q[2:0], 3'b000}) - 64'd1;

  // Pick multiplier operands for the current partial product
  always_comb begin
    mul_a = w[31:0];
    mul_b = MUR_M_LO;
    unique case (cmd.mul_step)
      MS_1:    mul_a = w[63:32];
      MS_2:    mul_b = MUR_M_HI;
      default: ;
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Work register source; the last multiplier step writes the product back
  always_comb begin
    w_next = w;
    unique case (cmd.w_sel)
      W_LEN:   w_next = {32'd0, len_q};
      W_WORD:  w_next = word_q;
      W_TAIL:  w_next = running_hash ^ (word_q & tail_mask);
      W_XS:    w_next = w ^ (w >> MUR_R);
      W_HXK:   w_next = running_hash ^ w;
      W_FIN0:  w_next = running_hash ^ (running_hash >> MUR_R);
      default: ;
    endcase
    if (cmd.mul_step == MS_2) begin
      w_next = {p[63:32] + prod[31:0], p[31:0]};
    end
  end

  // Advance the work register and the product accumulator
  always_ff @(posedge clk) begin
    w <= w_next;
    unique case (cmd.mul_step)
      MS_0:    p <= prod;
      MS_1:    p[63:32] <= p[63:32] + prod[31:0];
      default: ;
    endcase
  end

  // Running hash carries across items of one key
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= 64'd0;
    end else begin
      unique case (cmd.rh_sel)
        RH_SEED: running_hash <= {32'd0, seed_q} ^ w;
        RH_W:    running_hash <= w;
        default: ;
      endcase
    end
  end

  // Fold the finished hash one shift per cycle
  always_ff @(posedge clk) begin
    if (cmd.fold_init) begin
      j <= w;
      s <= w >> table_bits;
    end else if (cmd.fold_step) begin
      j <= j ^ s;
      s <= s >> table_bits;
    end
  end

  assign idx_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << table_bits);

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      table_index <= (j[62:0] & idx_mask[62:0]) | {62'd0, odd_q};
      full_hash   <= w;
    end
  end

  assign status.first     = first_q;
  assign status.last      = last_q;
  assign status.full      = bytes_q[3];
  assign status.zero      = (bytes_q == 4'd0);
  assign status.fold_done = (s == 64'd0) || (table_bits == 6'd0);

endmodule

>>> hw/rtl/mur64_ctrl.sv
// mur64_ctrl: sequencer of the hasher; steps the datapath through seed load,
// word mix, finalization and fold, and owns the handshakes. Uses mur64_pkg.
`timescale 1ns / 1ps

module mur64_ctrl import mur64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  state_t ret;
  state_t ret_next;
  logic   out_valid_next;

  // State, return point and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '{latch_in: 1'b0, w_sel: W_HOLD, mul_step: MS_NONE, rh_sel: RH_HOLD,
                   fold_init: 1'b0, fold_step: 1'b0, out_load: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (status.first) begin
          cmd.w_sel  = W_LEN;
          state_next = S_MUL0;
          ret_next   = S_SEED_DONE;
        end else begin
          state_next = S_WORD;
        end
      end
      S_SEED_DONE: begin
        cmd.rh_sel = RH_SEED;
        state_next = S_WORD;
      end
      S_WORD: begin
        priority if (status.full) begin
          cmd.w_sel  = W_WORD;
          state_next = S_MUL0;
          ret_next   = S_K1;
        end else if (status.zero) begin
          state_next = status.last ? S_FIN0 : S_IDLE;
        end else begin
          cmd.w_sel  = W_TAIL;
          state_next = S_MUL0;
          ret_next   = S_UPD;
        end
      end
      S_K1: begin
        cmd.w_sel  = W_XS;
        state_next = S_MUL0;
        ret_next   = S_K2;
      end
      S_K2: begin
        cmd.w_sel  = W_HXK;
        state_next = S_MUL0;
        ret_next   = S_UPD;
      end
      S_UPD: begin
        cmd.rh_sel = RH_W;
        state_next = status.last ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        cmd.w_sel  = W_FIN0;
        state_next = S_MUL0;
        ret_next   = S_FIN1;
      end
      S_FIN1: begin
        cmd.w_sel  = W_XS;
        state_next = S_FOLD_INIT;
      end
      S_FOLD_INIT: begin
        cmd.fold_init = 1'b1;
        state_next    = S_FOLD;
      end
      S_FOLD: begin
        priority if (!status.fold_done) begin
          cmd.fold_step = 1'b1;
        end else if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_MUL0: begin
        cmd.mul_step = MS_0;
        state_next   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_step = MS_1;
        state_next   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_step = MS_2;
        state_next   = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Set the result flag on load, drop it on transfer
  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  // An accepted item blocks the input until its work is done
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transfer");

  // Of the three multiplier steps, the first is always followed by the second
  a_mul_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL0) |=> (state == S_MUL1))
    else $error("multiplier sequence broken");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // A loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not offered");

endmodule

>>> hw/rtl/murmur64_table_index_hash_top.sv
// Channel | signals                          | transfer when
// in      | in_valid, in_stall, key fields   | in_valid && !in_stall
// out     | out_valid, out_stall, table_index, full_hash | out_valid && !out_stall
// cfg     | cfg_write, cfg_data (table_bits) | cfg_write
//
// One item at a time. An item is accepted in the idle state and then dispatched; an
// item that opens a key adds the seed multiply. An empty word is skipped, a partial
// word takes one 64-bit multiply and a full word three (each 64-bit multiply is three
// passes of one 32x32 multiplier). The last word adds finalization and then the fold,
// one shift per cycle until the shifted hash is zero (no shift when table_bits is 0).
// Reset (rst, synchronous) clears the running hash, sets table_bits to 8 and empties
// the result register. A stalled result holds; the next item is taken meanwhile and
// waits at its fold end until the result register is free.
// Depends on mur64_pkg, mur64_ctrl, mur64_dp.
`timescale 1ns / 1ps

module murmur64_table_index_hash_top import mur64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [3:0]  word_bytes,
  input  logic [63:0] key_word,
  input  logic [31:0] key_length,
  input  logic [31:0] seed,
  input  logic        odd_step,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] table_index,
  output logic [63:0] full_hash
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  mur64_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hash datapath
  mur64_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .first_word  (first_word),
    .last_word   (last_word),
    .word_bytes  (word_bytes),
    .key_word    (key_word),
    .key_length  (key_length),
    .seed        (seed),
    .odd_step    (odd_step),
    .cmd         (cmd),
    .status      (status),
    .table_index (table_index),
    .full_hash   (full_hash)
  );

endmodule

>>> verif/murmur64_table_index_hash_top_test.sv
// Testbench for murmur64_table_index_hash_top: streams keys, predicts hash and table index.
// Depends on mur64_pkg and the RTL of murmur64_table_index_hash_top; stands alone otherwise.
`timescale 1ns / 1ps

module murmur64_table_index_hash_top_test;
  import mur64_pkg::*;

  localparam int RANDOM_ITEMS     = 960;
  localparam int RANDOM_PHASES    = 6;
  localparam int SETTLE_CYCLES    = 120;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT      = 50000;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [3:0]  nbytes;
    logic [63:0] word;
    logic [31:0] len;
    logic [31:0] seed;
    logic        odd;
  } key_item_t;

  typedef struct {
    logic [62:0] index;
    logic [63:0] hash;
  } hash_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        first_word = 1'b0;
  logic        last_word = 1'b0;
  logic [3:0]  word_bytes = '0;
  logic [63:0] key_word = '0;
  logic [31:0] key_length = '0;
  logic [31:0] seed = '0;
  logic        odd_step = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [62:0] table_index;
  logic [63:0] full_hash;

  // Predictor state
  logic [63:0]  mix_state = '0;
  logic [5:0]   index_bits = TB_RESET;
  hash_result_t due_hashes[$];
  hash_result_t oldest_due;
  int           mismatch_count = 0;

  // Traffic shaping knobs
  logic tx_bursty = 1'b0;
  logic rx_choppy = 1'b0;
  logic hold_req = 1'b0;
  int   burst_left = 0;

  murmur64_table_index_hash_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .first_word (first_word),
    .last_word  (last_word),
    .word_bytes (word_bytes),
    .key_word   (key_word),
    .key_length (key_length),
    .seed       (seed),
    .odd_step   (odd_step),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .table_index(table_index),
    .full_hash  (full_hash)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("murmur64_table_index_hash_top test failed");
    $finish;
  end

  // XOR-fold the hash down to index_bits bits
  function automatic logic [62:0] fold_index_of(input logic [63:0] h, input logic [5:0] bits);
    logic [63:0] acc;
    int unsigned sh;
    acc = h;
    if (bits == 6'd0) return '0;
    for (sh = 32'(bits); sh < 64; sh += 32'(bits)) acc ^= h >> sh;
    acc &= (64'd1 << bits) - 64'd1;
    return acc[62:0];
  endfunction

  // Mix one accepted word into the running hash; queue a result on the last word
  function automatic void absorb_word(input key_item_t it);
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] mask;
    hash_result_t r;
    if (it.first) mix_state = {32'd0, it.seed} ^ ({32'd0, it.len} * MUR_M);
    h = mix_state;
    if (it.nbytes >= 4'd8) begin
      k = it.word * MUR_M;
      k ^= k >> MUR_R;
      k = k * MUR_M;
      h = (h ^ k) * MUR_M;
    end else if (it.nbytes != 4'd0) begin
      mask = (64'd1 << {it.nbytes, 3'b000}) - 64'd1;
      h = (h ^ (it.word & mask)) * MUR_M;
    end
    mix_state = h;
    if (it.last) begin
      h ^= h >> MUR_R;
      h = h * MUR_M;
      h ^= h >> MUR_R;
      r.hash = h;
      r.index = fold_index_of(h, index_bits);
      if (it.odd) r.index[0] = 1'b1;
      due_hashes.push_back(r);
    end
  endfunction

  function automatic key_item_t make_item(input logic first, input logic last,
                                          input logic [3:0] nbytes, input logic [63:0] word,
                                          input logic [31:0] len, input logic [31:0] sd,
                                          input logic odd);
    key_item_t it;
    it.first = first;
    it.last = last;
    it.nbytes = nbytes;
    it.word = word;
    it.len = len;
    it.seed = sd;
    it.odd = odd;
    return it;
  endfunction

  // Mostly random words, with the all-zero and all-one extremes now and then
  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic key_item_t noise_item();
    return make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     4'($urandom_range(0, 8)), random_word(), $urandom, $urandom,
                     1'($urandom_range(0, 1)));
  endfunction

  // Offer one item and hold it until the transfer; called at a rising edge
  task automatic send_item(input key_item_t it);
    int gap;
    gap = 0;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 20);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    first_word <= it.first;
    last_word  <= it.last;
    word_bytes <= it.nbytes;
    key_word   <= it.word;
    key_length <= it.len;
    seed       <= it.seed;
    odd_step   <= it.odd;
    do @(posedge clk); while (in_stall);
    absorb_word(it);
  endtask

  // Drop valid, wait for every due result, then let the block finish trailing work
  task automatic wait_idle();
    int n;
    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && due_hashes.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_index_bits(input logic [5:0] bits);
    cfg_write <= 1'b1;
    cfg_data  <= bits;
    @(posedge clk);
    cfg_write <= 1'b0;
    index_bits = bits;
  endtask

  // Key of full words, then a last word with 1 to 8 bytes (or an empty key); length may be random
  task automatic send_random_key(output int n_items);
    int nwords;
    int tail;
    int w;
    logic [31:0] len;
    key_item_t it;
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
    tail = (nwords == 1 && $urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    len = (nwords - 1) * 8 + tail;
    if ($urandom_range(0, 7) == 0) len = $urandom;
    for (w = 0; w < nwords; w++) begin
      it = make_item(w == 0, w == nwords - 1, (w == nwords - 1) ? 4'(tail) : 4'd8,
                     random_word(), (w == 0) ? len : $urandom, $urandom,
                     1'($urandom_range(0, 1)));
      send_item(it);
    end
    n_items = nwords;
  endtask

  // Extremes of each field and the corner cases of the key stream
  task automatic test_directed_keys();
    int n;
    tx_bursty = 1'b0;
    rx_choppy = 1'b0;
    // empty key: bytes ignored
    send_item(make_item(1'b1, 1'b1, 4'd0, '1, 32'd0, 32'd0, 1'b0));
    send_item(make_item(1'b1, 1'b1, 4'd8, '1, '1, '1, 1'b1));
    send_item(make_item(1'b1, 1'b1, 4'd8, '0, 32'd8, 32'd0, 1'b0));
    // tail masking for every partial size
    for (n = 1; n < 8; n++)
      send_item(make_item(1'b1, 1'b1, 4'(n), 64'hfedc_ba98_7654_3210, 32'(n),
                          32'h1234_5678 + 32'(n), 1'(n % 2)));
    // three-word key ending in a partial word
    send_item(make_item(1'b1, 1'b0, 4'd8, 64'h0102_0304_0506_0708, 32'd21, 32'h0000_00a5,
                        1'b0));
    send_item(make_item(1'b0, 1'b0, 4'd8, 64'h8877_6655_4433_2211, '1, '1, 1'b1));
    send_item(make_item(1'b0, 1'b1, 4'd5, 64'hffff_ffff_ffff_ffff, 32'd0, 32'd0, 1'b0));
    // partial word that is not last, then the key goes on
    send_item(make_item(1'b1, 1'b0, 4'd3, 64'hdead_beef_cafe_f00d, 32'd11, 32'h8000_0000,
                        1'b0));
    send_item(make_item(1'b0, 1'b1, 4'd8, 64'h0000_0000_8000_0001, 32'd0, 32'd0, 1'b1));
    // no first word: hash continues from the kept pre-finalization value
    send_item(make_item(1'b0, 1'b1, 4'd8, 64'h5555_aaaa_5555_aaaa, '1, '1, 1'b0));
    // declared length disagrees with the words sent
    send_item(make_item(1'b1, 1'b1, 4'd8, 64'h0f0f_0f0f_0f0f_0f0f, 32'd100, 32'h7fff_ffff,
                        1'b1));
    send_item(make_item(1'b1, 1'b1, 4'd0, 64'h1234, 32'd40, 32'h0000_0001, 1'b0));
    wait_idle();
  endtask

  // Step the index width through values from 1 to 63, both ends included
  task automatic test_index_width_sweep();
    logic [5:0] widths[6];
    int i;
    int n;
    int k;
    widths = '{6'd1, 6'd63, 6'd2, 6'd32, 6'd13, 6'd7};
    tx_bursty = 1'b1;
    rx_choppy = 1'b1;
    for (i = 0; i < 6; i++) begin
      set_index_bits(widths[i]);
      for (k = 0; k < 4; k++) send_random_key(n);
      send_item(make_item(1'b1, 1'b1, 4'd8, random_word(), 32'd8, $urandom, 1'b1));
      wait_idle();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_long_hold();
    int k;
    tx_bursty = 1'b0;
    rx_choppy = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 10; k++)
      send_item(make_item(1'b1, 1'b1, 4'd8, random_word(), 32'd8, $urandom,
                          1'($urandom_range(0, 1))));
    wait_idle();
  endtask

  // Sender stops until every due result has arrived, then resumes
  task automatic test_sender_pause();
    int n;
    int k;
    tx_bursty = 1'b1;
    rx_choppy = 1'b1;
    for (k = 0; k < 3; k++) begin
      send_random_key(n);
      in_valid <= 1'b0;
      while (due_hashes.size() != 0) @(posedge clk);
    end
    wait_idle();
  endtask

  // Mostly well-formed keys with random content, some stray items mixed in
  task automatic test_random_traffic();
    int phase;
    int sent;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_index_bits(6'd63);
        1: set_index_bits(6'd1);
        default: set_index_bits(6'($urandom_range(2, 62)));
      endcase
      tx_bursty = (phase != 2 && phase != 4);
      rx_choppy = (phase != 1 && phase != 4);
      sent = 0;
      while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(noise_item());
          sent++;
        end else begin
          send_random_key(n);
          sent += n;
        end
      end
      wait_idle();
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_keys();
    test_index_width_sweep();
    test_long_hold();
    test_sender_pause();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0 && due_hashes.size() == 0) begin
      $display("murmur64_table_index_hash_top test passed");
    end else begin
      $display("murmur64_table_index_hash_top test failed");
    end
    $finish;
  end

  // Receiver: long hold on request, otherwise free or alternating stall runs
  initial begin : receiver
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!rx_choppy) begin
        out_stall <= 1'b0;
      end else if (run == 0) begin
        out_stall <= ~out_stall;
        run = out_stall ? $urandom_range(1, 10) : $urandom_range(1, 8);
      end else begin
        run--;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    mismatch_count++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
  endtask

  // Compare each result transfer with the oldest due result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_hashes.size() == 0) begin
        report_mismatch("unexpected result, full_hash", '0, full_hash);
      end else begin
        oldest_due = due_hashes.pop_front();
        if (table_index !== oldest_due.index)
          report_mismatch("table_index", {1'b0, oldest_due.index}, {1'b0, table_index});
        if (full_hash !== oldest_due.hash)
          report_mismatch("full_hash", oldest_due.hash, full_hash);
      end
    end
  end

endmodule

>>> files.f
hw/rtl/mur64_pkg.sv
hw/rtl/mur64_dp.sv
hw/rtl/mur64_ctrl.sv
hw/rtl/murmur64_table_index_hash_top.sv
verif/murmur64_table_index_hash_top_test.sv
